// ===== hdl/tdau_pkg.sv =====
// ----------------------------------------------------------------------------
// tdau_pkg
// Types and constants shared by the time-of-day arithmetic unit.
// ----------------------------------------------------------------------------
package tdau_pkg;

	localparam logic [16:0] DAY_SECS  = 17'd86400;
	localparam logic [18:0] DAY_SECS2 = 19'd172800;
	localparam logic [18:0] DAY_SECS3 = 19'd259200;
	localparam logic [11:0] HOUR_SECS = 12'd3600;
	localparam logic [5:0]  MIN_SECS  = 6'd60;
	localparam logic [5:0]  MAX_HOUR  = 6'd23;
	localparam logic [5:0]  MAX_MIN   = 6'd59;

	// reciprocal multipliers, all round down so the quotient is low by at most one
	localparam logic [9:0]  DAY_RECIP        = 10'd776;
	localparam int          DAY_RECIP_SHIFT  = 26;
	localparam logic [10:0] HOUR_RECIP       = 11'd1165;
	localparam int          HOUR_RECIP_SHIFT = 22;
	localparam logic [10:0] MIN_RECIP        = 11'd1092;
	localparam int          MIN_RECIP_SHIFT  = 16;

	localparam int LATENCY = 8;

	typedef enum logic [2:0] {
		KIND_ADD      = 3'd0,
		KIND_SUB      = 3'd1,
		KIND_DURATION = 3'd2,
		KIND_COMPARE  = 3'd3,
		KIND_TO_HMS   = 3'd4,
		KIND_TO_SECS  = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  hours_a;
		logic [5:0]  minutes_a;
		logic [5:0]  seconds_a;
		logic [5:0]  hours_b;
		logic [5:0]  minutes_b;
		logic [5:0]  seconds_b;
		logic [19:0] offset_seconds;
	} req_t;

	typedef struct packed {
		logic [4:0]  result_hours;
		logic [5:0]  result_minutes;
		logic [5:0]  result_seconds;
		logic [17:0] seconds_count;
		logic        equal;
		logic        less;
		logic        greater;
		logic        valid_a;
	} res_t;

	typedef struct packed {
		logic [17:0] seconds_count;
		logic        equal;
		logic        less;
		logic        greater;
		logic        valid_a;
	} side_t;

	function automatic logic [17:0] to_secs(input logic [5:0] h, input logic [5:0] m,
		input logic [5:0] s);
		return 18'(h) * 18'(HOUR_SECS) + 18'(m) * 18'(MIN_SECS) + 18'(s);
	endfunction

endpackage

// ===== hdl/time_of_day_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_unit
// Commands pass through registered stages s1 to s8; done is the s8 valid bit.
// Throughput: one command per cycle; busy is always low, nothing stalls.
// Reset clears all stage valid bits; commands in flight are dropped.
// ----------------------------------------------------------------------------
module time_of_day_arithmetic_unit import tdau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	logic        accept;
	logic        v_s1, v_s2, v_s3, v_s4;
	kind_t       kind_s1, kind_s2;
	logic [17:0] secs_a_s1, secs_b_s1, secs_a_s2;
	logic [19:0] off_s1;
	logic [3:0]  q_s1;
	logic        equal_s1, valid_a_s1;
	logic [17:0] r_s2;
	side_t       side_s2, side_s3, side_s4;
	logic [18:0] t_s3;
	logic [16:0] t_s4;

	logic [29:0] dprod;
	logic [16:0] off_mod;
	side_t       side_nxt;
	logic [18:0] t_nxt;
	logic [16:0] t_red;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: seconds of A and B, day quotient estimate of the offset, A/B equality, A range check
	always_comb begin
		dprod = 30'(req.offset_seconds) * 30'(DAY_RECIP);
	end

	always_ff @(posedge clk) begin
		kind_s1    <= req.kind;
		secs_a_s1  <= to_secs(req.hours_a, req.minutes_a, req.seconds_a);
		secs_b_s1  <= to_secs(req.hours_b, req.minutes_b, req.seconds_b);
		off_s1     <= req.offset_seconds;
		q_s1       <= 4'(dprod >> DAY_RECIP_SHIFT);
		equal_s1   <= (req.hours_a == req.hours_b) && (req.minutes_a == req.minutes_b)
			&& (req.seconds_a == req.seconds_b);
		valid_a_s1 <= (req.hours_a <= MAX_HOUR) && (req.minutes_a <= MAX_MIN)
			&& (req.seconds_a <= MAX_MIN);
	end

	// s2: offset remainder, duration, compare and to-seconds result
	always_comb begin
		side_nxt = '0;
		side_nxt.valid_a = valid_a_s1;
		case (kind_s1)
			KIND_DURATION: begin
				if (secs_a_s1 > secs_b_s1)
					side_nxt.seconds_count = secs_b_s1 + 18'(DAY_SECS) - secs_a_s1;
				else
					side_nxt.seconds_count = secs_b_s1 - secs_a_s1;
			end
			KIND_COMPARE: begin
				side_nxt.equal   = equal_s1;
				side_nxt.less    = secs_a_s1 < secs_b_s1;
				side_nxt.greater = secs_a_s1 > secs_b_s1;
			end
			KIND_TO_SECS: side_nxt.seconds_count = secs_a_s1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		kind_s2   <= kind_s1;
		secs_a_s2 <= secs_a_s1;
		r_s2      <= 18'(21'(off_s1) - 21'(q_s1) * 21'(DAY_SECS));
		side_s2   <= side_nxt;
	end

	// s3: finish offset reduction, form time sum
	always_comb begin
		off_mod = (r_s2 >= 18'(DAY_SECS)) ? 17'(r_s2 - 18'(DAY_SECS)) : 17'(r_s2);
		case (kind_s2)
			KIND_ADD:    t_nxt = 19'(secs_a_s2) + 19'(off_mod);
			KIND_SUB:    t_nxt = 19'(secs_a_s2) + 19'(DAY_SECS) - 19'(off_mod);
			KIND_TO_HMS: t_nxt = 19'(off_mod);
			default:     t_nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		t_s3    <= t_nxt;
		side_s3 <= side_s2;
	end

	// s4: wrap to one day
	always_comb begin
		if (t_s3 >= DAY_SECS3)
			t_red = 17'(t_s3 - DAY_SECS3);
		else if (t_s3 >= DAY_SECS2)
			t_red = 17'(t_s3 - DAY_SECS2);
		else if (t_s3 >= 19'(DAY_SECS))
			t_red = 17'(t_s3 - 19'(DAY_SECS));
		else
			t_red = 17'(t_s3);
	end

	always_ff @(posedge clk) begin
		t_s4    <= t_red;
		side_s4 <= side_s3;
	end

	tdau_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (v_s4),
		.secs   (t_s4),
		.side   (side_s4),
		.done   (done),
		.res    (res)
	);

endmodule

// ===== hdl/tdau_split.sv =====
// ----------------------------------------------------------------------------
// tdau_split
// Four-stage split of a seconds-of-day value into hours, minutes, seconds.
// ----------------------------------------------------------------------------
module tdau_split import tdau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic [16:0] secs,
	input  side_t       side,
	output logic        done,
	output res_t        res
);

	logic        v_s5, v_s6, v_s7, v_s8;
	logic [16:0] secs_s5;
	logic [4:0]  h_s5, h_s6, h_s7;
	logic [11:0] rem_s6, rem_s7;
	logic [5:0]  m_s7;
	side_t       side_s5, side_s6, side_s7;
	res_t        res_s8;

	logic [27:0] hprod;
	logic [12:0] hrem;
	logic [22:0] mprod;
	logic [6:0]  srem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s5 <= valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// s5: hour estimate
	always_comb begin
		hprod = 28'(secs) * 28'(HOUR_RECIP);
	end

	always_ff @(posedge clk) begin
		secs_s5 <= secs;
		h_s5    <= 5'(hprod >> HOUR_RECIP_SHIFT);
		side_s5 <= side;
	end

	// s6: hour correction
	always_comb begin
		hrem = 13'(secs_s5 - 17'(h_s5) * 17'(HOUR_SECS));
	end

	always_ff @(posedge clk) begin
		if (hrem >= 13'(HOUR_SECS)) begin
			h_s6   <= h_s5 + 5'd1;
			rem_s6 <= 12'(hrem - 13'(HOUR_SECS));
		end else begin
			h_s6   <= h_s5;
			rem_s6 <= 12'(hrem);
		end
		side_s6 <= side_s5;
	end

	// s7: minute estimate
	always_comb begin
		mprod = 23'(rem_s6) * 23'(MIN_RECIP);
	end

	always_ff @(posedge clk) begin
		h_s7    <= h_s6;
		rem_s7  <= rem_s6;
		m_s7    <= 6'(mprod >> MIN_RECIP_SHIFT);
		side_s7 <= side_s6;
	end

	// s8: minute correction and result assembly
	always_comb begin
		srem = 7'(rem_s7 - 12'(m_s7) * 12'(MIN_SECS));
	end

	always_ff @(posedge clk) begin
		res_s8.result_hours <= h_s7;
		if (srem >= 7'(MIN_SECS)) begin
			res_s8.result_minutes <= m_s7 + 6'd1;
			res_s8.result_seconds <= 6'(srem - 7'(MIN_SECS));
		end else begin
			res_s8.result_minutes <= m_s7;
			res_s8.result_seconds <= 6'(srem);
		end
		res_s8.seconds_count <= side_s7.seconds_count;
		res_s8.equal         <= side_s7.equal;
		res_s8.less          <= side_s7.less;
		res_s8.greater       <= side_s7.greater;
		res_s8.valid_a       <= side_s7.valid_a;
	end

	assign done = v_s8;
	assign res  = res_s8;

endmodule

// ===== hdl/tdau_checker.sv =====
// ----------------------------------------------------------------------------
// tdau_checker
// Port-level checks for the time-of-day arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module tdau_checker import tdau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input res_t res
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_beat_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##8 done)
		else $error("result beat missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result beat without command");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.result_hours <= 5'd23 && res.result_minutes <= 6'd59
			&& res.result_seconds <= 6'd59 && !(res.less && res.greater))
		else $error("result out of range");

	a_valid_a: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.valid_a == ($past(req.hours_a, LATENCY) <= 6'd23
			&& $past(req.minutes_a, LATENCY) <= 6'd59
			&& $past(req.seconds_a, LATENCY) <= 6'd59))
		else $error("valid_a mismatch");

endmodule

bind time_of_day_arithmetic_unit tdau_checker u_tdau_checker (.*);

// ===== verif/tb_time_of_day_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// tb_time_of_day_arithmetic_unit
// Self-checking bench for the time-of-day arithmetic unit. Commands go in
// through the start/busy handshake with random gaps. Each command's
// expected result is computed in the bench and queued. Results are then
// compared field by field in order as the done strobes arrive. Covers
// directed corner cases, a drained pause and a long random run.
// ----------------------------------------------------------------------------
module tb_time_of_day_arithmetic_unit;
	import tdau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DAY_LEN  = 86400;
	localparam int unsigned HOUR_LEN = 3600;
	localparam int unsigned MIN_LEN  = 60;
	localparam int unsigned MASK_18  = 32'h3FFFF;
	localparam logic [19:0] OFFSET_MAX = 20'hFFFFF;
	localparam logic [2:0]  KIND_SPARE_6 = 3'd6;
	localparam logic [2:0]  KIND_SPARE_7 = 3'd7;
	localparam int RANDOM_BEATS = 450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;

	res_t expected_results[$];
	int   mismatches = 0;
	bit   back_to_back = 1'b0;

	time_of_day_arithmetic_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [31:0] hms_to_secs(input logic [5:0] h, input logic [5:0] m,
		input logic [5:0] s);
		return 32'(h) * HOUR_LEN + 32'(m) * MIN_LEN + 32'(s);
	endfunction

	function automatic res_t predict_result(input req_t cmd);
		res_t        r;
		logic [31:0] secs_a;
		logic [31:0] secs_b;
		logic [31:0] off;
		logic [31:0] t;
		bit          gives_time;
		r = '0;
		t = '0;
		gives_time = 1'b0;
		secs_a = hms_to_secs(cmd.hours_a, cmd.minutes_a, cmd.seconds_a);
		secs_b = hms_to_secs(cmd.hours_b, cmd.minutes_b, cmd.seconds_b);
		off = 32'(cmd.offset_seconds) % DAY_LEN;
		case (cmd.kind)
			KIND_ADD: begin
				t = secs_a + off;
				gives_time = 1'b1;
			end
			KIND_SUB: begin
				t = secs_a + DAY_LEN - off;
				gives_time = 1'b1;
			end
			KIND_DURATION: begin
				if (secs_a > secs_b)
					r.seconds_count = 18'((secs_b + DAY_LEN - secs_a) & MASK_18);
				else
					r.seconds_count = 18'((secs_b - secs_a) & MASK_18);
			end
			KIND_COMPARE: begin
				r.equal = (cmd.hours_a == cmd.hours_b) && (cmd.minutes_a == cmd.minutes_b)
					&& (cmd.seconds_a == cmd.seconds_b);
				r.less = secs_a < secs_b;
				r.greater = secs_a > secs_b;
			end
			KIND_TO_HMS: begin
				t = off;
				gives_time = 1'b1;
			end
			KIND_TO_SECS: begin
				r.seconds_count = 18'(secs_a & MASK_18);
			end
			default: begin
			end
		endcase
		if (gives_time) begin
			t = t % DAY_LEN;
			r.result_hours = 5'(t / HOUR_LEN);
			r.result_minutes = 6'((t % HOUR_LEN) / MIN_LEN);
			r.result_seconds = 6'((t % HOUR_LEN) % MIN_LEN);
		end
		r.valid_a = (cmd.hours_a <= 6'd23) && (cmd.minutes_a <= 6'd59)
			&& (cmd.seconds_a <= 6'd59);
		return r;
	endfunction

	function automatic req_t make_cmd(input logic [2:0] k, input int ha, input int ma,
		input int sa, input int hb, input int mb, input int sb, input logic [19:0] off);
		req_t c;
		c.kind = kind_t'(k);
		c.hours_a = 6'(ha);
		c.minutes_a = 6'(ma);
		c.seconds_a = 6'(sa);
		c.hours_b = 6'(hb);
		c.minutes_b = 6'(mb);
		c.seconds_b = 6'(sb);
		c.offset_seconds = off;
		return c;
	endfunction

	function automatic req_t random_cmd();
		req_t c;
		int   pick;
		c = '0;
		pick = $urandom_range(0, 19);
		if (pick < 18)
			c.kind = kind_t'(3'(pick % 6));
		else
			c.kind = kind_t'(pick == 18 ? KIND_SPARE_6 : KIND_SPARE_7);
		if ($urandom_range(0, 9) < 7) begin
			c.hours_a = 6'($urandom_range(0, 23));
			c.minutes_a = 6'($urandom_range(0, 59));
			c.seconds_a = 6'($urandom_range(0, 59));
			c.hours_b = 6'($urandom_range(0, 23));
			c.minutes_b = 6'($urandom_range(0, 59));
			c.seconds_b = 6'($urandom_range(0, 59));
		end else begin
			c.hours_a = 6'($urandom());
			c.minutes_a = 6'($urandom());
			c.seconds_a = 6'($urandom());
			c.hours_b = 6'($urandom());
			c.minutes_b = 6'($urandom());
			c.seconds_b = 6'($urandom());
		end
		if ($urandom_range(0, 6) == 0) begin
			c.hours_b = c.hours_a;
			c.minutes_b = c.minutes_a;
			c.seconds_b = c.seconds_a;
		end
		case ($urandom_range(0, 3))
			0: c.offset_seconds = 20'($urandom());
			1: c.offset_seconds = 20'($urandom_range(0, DAY_LEN - 1));
			2: begin
				case ($urandom_range(0, 3))
					0: c.offset_seconds = '0;
					1: c.offset_seconds = 20'(DAY_LEN - 1);
					2: c.offset_seconds = 20'(DAY_LEN);
					default: c.offset_seconds = OFFSET_MAX;
				endcase
			end
			default: c.offset_seconds = 20'($urandom_range(0, HOUR_LEN));
		endcase
		return c;
	endfunction

	// called at a rising edge; returns at the edge that accepts the beat
	task automatic send_cmd(input req_t cmd);
		int gap;
		gap = back_to_back ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= cmd;
		do @(negedge clk); while (busy);
		@(posedge clk);
		expected_results.push_back(predict_result(cmd));
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic test_extremes();
		for (int k = 0; k < 8; k++) begin
			send_cmd(make_cmd(3'(k), 0, 0, 0, 0, 0, 0, '0));
			send_cmd(make_cmd(3'(k), 63, 63, 63, 63, 63, 63, OFFSET_MAX));
		end
	endtask

	task automatic test_corner_cases();
		send_cmd(make_cmd(KIND_ADD, 23, 59, 59, 0, 0, 0, 20'd1));
		send_cmd(make_cmd(KIND_SUB, 0, 0, 0, 0, 0, 0, OFFSET_MAX));
		send_cmd(make_cmd(KIND_SUB, 12, 0, 0, 0, 0, 0, 20'(DAY_LEN)));
		send_cmd(make_cmd(KIND_DURATION, 22, 0, 0, 1, 30, 0, '0));
		send_cmd(make_cmd(KIND_DURATION, 63, 63, 63, 0, 0, 0, '0));
		send_cmd(make_cmd(KIND_COMPARE, 0, 1, 0, 0, 0, 60, '0));
		send_cmd(make_cmd(KIND_COMPARE, 10, 20, 30, 10, 20, 31, '0));
		send_cmd(make_cmd(KIND_COMPARE, 10, 20, 31, 10, 20, 30, '0));
		send_cmd(make_cmd(KIND_TO_HMS, 0, 0, 0, 0, 0, 0, 20'(DAY_LEN - 1)));
		send_cmd(make_cmd(KIND_TO_SECS, 23, 59, 59, 0, 0, 0, '0));
		send_cmd(make_cmd(KIND_TO_SECS, 24, 0, 0, 0, 0, 0, '0));
		send_cmd(make_cmd(KIND_TO_SECS, 0, 60, 0, 0, 0, 0, '0));
		send_cmd(make_cmd(KIND_TO_SECS, 0, 0, 60, 0, 0, 0, '0));
	endtask

	task automatic test_random();
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 50 == 0)
				back_to_back = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_BEATS / 2)
				hold_until_drained();
			send_cmd(random_cmd());
		end
		back_to_back = 1'b0;
	endtask

	always @(negedge clk) begin : check_results
		res_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (res.result_hours !== want.result_hours) begin
					$error("result_hours: expected %0d, got %0d", want.result_hours,
						res.result_hours);
					mismatches++;
				end
				if (res.result_minutes !== want.result_minutes) begin
					$error("result_minutes: expected %0d, got %0d", want.result_minutes,
						res.result_minutes);
					mismatches++;
				end
				if (res.result_seconds !== want.result_seconds) begin
					$error("result_seconds: expected %0d, got %0d", want.result_seconds,
						res.result_seconds);
					mismatches++;
				end
				if (res.seconds_count !== want.seconds_count) begin
					$error("seconds_count: expected %0d, got %0d", want.seconds_count,
						res.seconds_count);
					mismatches++;
				end
				if (res.equal !== want.equal) begin
					$error("equal: expected %0d, got %0d", want.equal, res.equal);
					mismatches++;
				end
				if (res.less !== want.less) begin
					$error("less: expected %0d, got %0d", want.less, res.less);
					mismatches++;
				end
				if (res.greater !== want.greater) begin
					$error("greater: expected %0d, got %0d", want.greater, res.greater);
					mismatches++;
				end
				if (res.valid_a !== want.valid_a) begin
					$error("valid_a: expected %0d, got %0d", want.valid_a, res.valid_a);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_corner_cases();
		test_random();
		hold_until_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
